FILE: hw/rtl/ahc_pkg.sv
// shared constants and codes of the adaptive hysteresis comparator
package ahc_pkg;

	// default sizes
	localparam int DEF_MAX_DC_HALF  = 2048;
	localparam int DEF_MAX_RMS_HALF = 512;
	localparam int DEF_SAMPLE_BITS  = 16;

	// register field widths
	localparam int DC_HALF_W  = 12;
	localparam int RMS_HALF_W = 10;
	localparam int LEVEL_W    = 15;
	localparam int FRAC_W     = 16;

	// register reset values
	localparam logic [DC_HALF_W-1:0]  DC_HALF_RST  = 12'd1102;
	localparam logic [RMS_HALF_W-1:0] RMS_HALF_RST = 10'd220;
	localparam logic [LEVEL_W-1:0]    SILENCE_RST  = 15'd655;
	localparam logic [LEVEL_W-1:0]    HYST_MIN_RST = 15'd655;
	localparam logic [FRAC_W-1:0]     HYST_FRAC_RST = 16'd5243;

	// configuration port
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;
	localparam logic [2:0] REG_DC_HALF   = 3'd0;
	localparam logic [2:0] REG_RMS_HALF  = 3'd1;
	localparam logic [2:0] REG_SILENCE   = 3'd2;
	localparam logic [2:0] REG_HYST_MIN  = 3'd3;
	localparam logic [2:0] REG_HYST_FRAC = 3'd4;

	// request kinds on tuser
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_FLUSH  = 1'b1;

	// output level codes
	localparam int OUT_W = 8;
	localparam logic [1:0] LVL_SILENT = 2'b00;
	localparam logic [1:0] LVL_HIGH   = 2'b01;
	localparam logic [1:0] LVL_LOW    = 2'b11;

endpackage

FILE: hw/rtl/adaptive_hysteresis_comparator_unit.sv
// adaptive hysteresis comparator: dc removal, local rms and schmitt trigger
//
// Input requests arrive on s_tvalid/s_tready: tuser is the kind (0 sample,
// 1 flush tick), tdata the signed Q1.15 sample. Results leave on
// m_tvalid/m_tready: tdata[1:0] is the level (-1 low, 0 silence, +1 high),
// tlast marks the final output of a stream. Registers are to be written through
// the APB port while the block is idle; the block itself does not enforce this.
// Each sample is centered by a moving mean over +-dc_half samples and judged
// against a moving rms over +-rms_half centered samples, so the output lags
// the input by dc_half+rms_half requests; flush ticks drain the tail, one
// output each.
// A sample still filling the dc window only updates the raw sum and count; one that
// adds a centered value runs the bit-serial divider once for the rounded mean, and one
// with an output runs it a second time for the mean square unless the window is silent.
// s_tready is high only between requests. A result waits in the output register
// while the next request is taken; the block stalls only when a second result
// is ready before the first has been taken.
// Reset clears sums, counts and the stream flags at once; the window memories
// need no clearing because only entries written in the current stream are read.
module adaptive_hysteresis_comparator_unit
	import ahc_pkg::*;
#(
	parameter int MAX_DC_HALF  = DEF_MAX_DC_HALF,
	parameter int MAX_RMS_HALF = DEF_MAX_RMS_HALF,
	parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// sample
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
	// action
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// level
	output logic [OUT_W-1:0]                     m_tdata,
	output logic                                 m_tlast,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [APB_AW-1:0]                    paddr,
	input  logic [APB_DW-1:0]                    pwdata,
	output logic [APB_DW-1:0]                    prdata,
	output logic                                 pready
);

	localparam int SB        = SAMPLE_BITS;
	localparam int CW        = SB + 1;
	localparam int RAW_DEPTH = 2 * MAX_DC_HALF + 2;
	localparam int RAW_AW    = $clog2(RAW_DEPTH);
	localparam int RCW       = RAW_AW;
	localparam int CEN_DEPTH = 2 * MAX_RMS_HALF + 2;
	localparam int CEN_AW    = $clog2(CEN_DEPTH);
	localparam int SCW       = CEN_AW;
	localparam int RSW       = SB + RCW;
	localparam int SQW       = 2 * SB;
	localparam int SSW       = SQW + SCW;
	localparam int NW        = RSW + 1;
	localparam int DVW       = (NW > SSW) ? NW : SSW;
	localparam int DDW       = ((RCW + 1) > SCW) ? (RCW + 1) : SCW;
	localparam int DCNTW     = $clog2(DVW + 1);
	localparam int SLW       = 2 * LEVEL_W;
	localparam int SPW       = SLW + SCW;
	localparam int T2W       = SQW + FRAC_W;

	// sequencer codes
	localparam logic [4:0] S_IDLE       = 5'd0;
	localparam logic [4:0] S_DC_CHK     = 5'd1;
	localparam logic [4:0] S_DC_START   = 5'd2;
	localparam logic [4:0] S_DC_RM_RD   = 5'd3;
	localparam logic [4:0] S_DC_RM_SUB  = 5'd4;
	localparam logic [4:0] S_DC_X_RD    = 5'd5;
	localparam logic [4:0] S_DC_DIV_LD  = 5'd6;
	localparam logic [4:0] S_DIV        = 5'd7;
	localparam logic [4:0] S_DC_MEAN    = 5'd8;
	localparam logic [4:0] S_CEN_WR     = 5'd9;
	localparam logic [4:0] S_CEN_ADD    = 5'd10;
	localparam logic [4:0] S_CEN_START  = 5'd11;
	localparam logic [4:0] S_CEN_RM_RD  = 5'd12;
	localparam logic [4:0] S_CEN_RM_SQ  = 5'd13;
	localparam logic [4:0] S_CEN_RM_SUB = 5'd14;
	localparam logic [4:0] S_CEN_C_RD   = 5'd15;
	localparam logic [4:0] S_CEN_C_GET  = 5'd16;
	localparam logic [4:0] S_CEN_SQ     = 5'd17;
	localparam logic [4:0] S_CEN_SIL    = 5'd18;
	localparam logic [4:0] S_CEN_CMP    = 5'd19;
	localparam logic [4:0] S_CEN_T2     = 5'd20;
	localparam logic [4:0] S_CEN_DEC    = 5'd21;
	localparam logic [4:0] S_OUT        = 5'd22;
	localparam logic [4:0] S_DRAIN      = 5'd23;

	// configuration registers
	logic [DC_HALF_W-1:0]  dc_half_q;
	logic [RMS_HALF_W-1:0] rms_half_q;
	logic [LEVEL_W-1:0]    silence_level_q;
	logic [LEVEL_W-1:0]    hyst_min_q;
	logic [FRAC_W-1:0]     hyst_frac_q;

	// control state
	logic [4:0]              state_q;
	logic                    active_q, draining_q, trig_q;
	logic [RCW-1:0]          dc_use_q, pend_dc_q, raw_count_q;
	logic [SCW-1:0]          rms_use_q, pend_rms_q, scount_q;
	logic [RAW_AW-1:0]       wr_raw_q;
	logic [CEN_AW-1:0]       wr_cen_q;
	logic signed [RSW-1:0]   raw_sum_q;
	logic [SSW-1:0]          ssum_q;
	logic [DCNTW-1:0]        div_cnt_q;
	logic                    div_sel_q;
	logic                    m_tvalid_q;

	// datapath registers
	logic signed [SB-1:0]    x_q;
	logic signed [CW-1:0]    c_q;
	logic [SQW-1:0]          sq_q;
	logic [SLW-1:0]          sl_sq_q;
	logic [SPW-1:0]          sil_prod_q;
	logic [FRAC_W-1:0]       f2_q;
	logic [SQW-1:0]          t2_q;
	logic [DVW-1:0]          num_q, quo_q;
	logic [DDW-1:0]          den_q, rem_q;
	logic                    mean_neg_q, mean_zero_q;
	logic [1:0]              lvl_q;
	logic [OUT_W-1:0]        m_tdata_q;
	logic                    m_tlast_q;

	// memories
	logic signed [SB-1:0]    raw_mem [RAW_DEPTH];
	logic signed [CW-1:0]    cen_mem [CEN_DEPTH];
	logic signed [SB-1:0]    raw_rd_q;
	logic signed [CW-1:0]    cen_rd_q;
	logic [RAW_AW-1:0]       raw_ra;
	logic [CEN_AW-1:0]       cen_ra;
	logic                    raw_we, cen_we;

	logic                    s_accept, cfg_we, out_go, out_last, end_stream;
	logic signed [SB-1:0]    s_sample;
	logic [RSW-1:0]          raw_mag;
	logic [NW-1:0]           div1_num;
	logic [DDW:0]            div_t;
	logic                    div_ge;
	logic [DDW-1:0]          div_rem_n;
	logic signed [CW:0]      x_ext, q_ext, c_full;
	logic signed [CW-1:0]    sq_src;
	logic signed [2*CW-1:0]  sq_prod;
	logic [SQW-1:0]          ms;
	logic [T2W-1:0]          t2_full;
	logic [CW-1:0]           c_mag;
	logic                    c2_ok, hm_ok, go_high, go_low, trig_n;
	logic                    dc_sat, rms_sat;

	// pointer arithmetic on the rings
	function automatic logic [RAW_AW-1:0] raw_back(input logic [RAW_AW-1:0] wr,
			input logic [RCW-1:0] k);
		logic [RAW_AW:0] t;
		t = (RAW_AW+1)'(wr) + (RAW_AW+1)'(RAW_DEPTH) - (RAW_AW+1)'(k);
		if (t >= (RAW_AW+1)'(RAW_DEPTH)) begin
			t = t - (RAW_AW+1)'(RAW_DEPTH);
		end
		return t[RAW_AW-1:0];
	endfunction

	function automatic logic [CEN_AW-1:0] cen_back(input logic [CEN_AW-1:0] wr,
			input logic [SCW-1:0] k);
		logic [CEN_AW:0] t;
		t = (CEN_AW+1)'(wr) + (CEN_AW+1)'(CEN_DEPTH) - (CEN_AW+1)'(k);
		if (t >= (CEN_AW+1)'(CEN_DEPTH)) begin
			t = t - (CEN_AW+1)'(CEN_DEPTH);
		end
		return t[CEN_AW-1:0];
	endfunction

	assign s_tready = (state_q == S_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign s_sample = $signed(s_tdata[SB-1:0]);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign pready   = 1'b1;
	assign cfg_we   = psel && penable && pwrite;

	// register read
	always_comb begin
		unique case (paddr[4:2])
			REG_DC_HALF:   prdata = APB_DW'(dc_half_q);
			REG_RMS_HALF:  prdata = APB_DW'(rms_half_q);
			REG_SILENCE:   prdata = APB_DW'(silence_level_q);
			REG_HYST_MIN:  prdata = APB_DW'(hyst_min_q);
			REG_HYST_FRAC: prdata = APB_DW'(hyst_frac_q);
			default:       prdata = '0;
		endcase
	end

	// window sizes clamp at the memory limits
	assign dc_sat  = 32'(dc_half_q) > 32'(MAX_DC_HALF);
	assign rms_sat = 32'(rms_half_q) > 32'(MAX_RMS_HALF);

	// memory ports
	assign raw_we = s_accept && (s_tuser == ACT_SAMPLE) && !draining_q;
	assign raw_ra = (state_q == S_DC_RM_RD) ? raw_back(wr_raw_q, raw_count_q)
	                                        : raw_back(wr_raw_q, pend_dc_q);
	assign cen_we = (state_q == S_CEN_WR);
	assign cen_ra = (state_q == S_CEN_RM_RD) ? cen_back(wr_cen_q, scount_q)
	                                         : cen_back(wr_cen_q, pend_rms_q);

	always_ff @(posedge clk) begin
		if (raw_we) begin
			raw_mem[wr_raw_q] <= s_sample;
		end
		raw_rd_q <= raw_mem[raw_ra];
	end

	always_ff @(posedge clk) begin
		if (cen_we) begin
			cen_mem[wr_cen_q] <= c_q;
		end
		cen_rd_q <= cen_mem[cen_ra];
	end

	// divider step, one quotient bit per cycle
	assign raw_mag   = raw_sum_q[RSW-1] ? RSW'(-raw_sum_q) : RSW'(raw_sum_q);
	assign div1_num  = {raw_mag, 1'b0} + NW'(raw_count_q);
	assign div_t     = {rem_q, num_q[DVW-1]};
	assign div_ge    = div_t >= {1'b0, den_q};
	assign div_rem_n = div_ge ? DDW'(div_t - {1'b0, den_q}) : DDW'(div_t);

	// centered value from the rounded mean
	assign x_ext  = (CW+1)'(x_q);
	assign q_ext  = mean_zero_q ? '0 : $signed({2'b00, quo_q[SB-1:0]});
	assign c_full = mean_neg_q ? (x_ext + q_ext) : (x_ext - q_ext);

	// shared squarer
	assign sq_src  = (state_q == S_CEN_RM_SQ) ? cen_rd_q : c_q;
	assign sq_prod = sq_src * sq_src;

	// threshold and trigger decision
	assign ms      = quo_q[SQW-1:0];
	assign t2_full = T2W'(ms) * T2W'(f2_q);
	assign c_mag   = c_q[CW-1] ? CW'(-c_q) : CW'(c_q);
	assign c2_ok   = sq_q >= t2_q;
	assign hm_ok   = 32'(c_mag) >= 32'(hyst_min_q);
	assign go_high = !c_q[CW-1] && hm_ok && c2_ok;
	assign go_low  = (c_q[CW-1] || (c_q == '0)) && hm_ok && c2_ok;
	assign trig_n  = go_high ? 1'b1 : (go_low ? 1'b0 : trig_q);

	// output hand-off and end of stream
	assign out_go     = (state_q == S_OUT) && (!m_tvalid_q || m_tready);
	assign out_last   = draining_q && (pend_dc_q == '0) && (pend_rms_q == '0);
	assign end_stream = (out_go && out_last) ||
	                    ((state_q == S_DRAIN) && (pend_dc_q == '0) && (pend_rms_q == '0));

	// sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_half_q       <= DC_HALF_RST;
			rms_half_q      <= RMS_HALF_RST;
			silence_level_q <= SILENCE_RST;
			hyst_min_q      <= HYST_MIN_RST;
			hyst_frac_q     <= HYST_FRAC_RST;
			state_q         <= S_IDLE;
			active_q        <= 1'b0;
			draining_q      <= 1'b0;
			trig_q          <= 1'b1;
			dc_use_q        <= '0;
			rms_use_q       <= '0;
			pend_dc_q       <= '0;
			pend_rms_q      <= '0;
			raw_count_q     <= '0;
			scount_q        <= '0;
			wr_raw_q        <= '0;
			wr_cen_q        <= '0;
			raw_sum_q       <= '0;
			ssum_q          <= '0;
			div_cnt_q       <= '0;
			div_sel_q       <= 1'b0;
			m_tvalid_q      <= 1'b0;
		end else begin
			// register writes
			if (cfg_we) begin
				unique case (paddr[4:2])
					REG_DC_HALF:   dc_half_q       <= pwdata[DC_HALF_W-1:0];
					REG_RMS_HALF:  rms_half_q      <= pwdata[RMS_HALF_W-1:0];
					REG_SILENCE:   silence_level_q <= pwdata[LEVEL_W-1:0];
					REG_HYST_MIN:  hyst_min_q      <= pwdata[LEVEL_W-1:0];
					REG_HYST_FRAC: hyst_frac_q     <= pwdata[FRAC_W-1:0];
					default: ;
				endcase
			end

			// result valid: set on hand-off, cleared when taken
			if (out_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						if (s_tuser == ACT_SAMPLE) begin
							if (!draining_q) begin
								if (!active_q) begin
									active_q  <= 1'b1;
									trig_q    <= 1'b1;
									dc_use_q  <= dc_sat ? RCW'(MAX_DC_HALF) : RCW'(dc_half_q);
									rms_use_q <= rms_sat ? SCW'(MAX_RMS_HALF) : SCW'(rms_half_q);
								end
								wr_raw_q    <= (wr_raw_q == RAW_AW'(RAW_DEPTH - 1)) ? '0
								                                                   : wr_raw_q + 1'b1;
								raw_sum_q   <= raw_sum_q + RSW'(s_sample);
								raw_count_q <= raw_count_q + 1'b1;
								pend_dc_q   <= pend_dc_q + 1'b1;
								state_q     <= S_DC_CHK;
							end
						end else if (active_q) begin
							draining_q <= 1'b1;
							state_q    <= S_DRAIN;
						end
					end
				end
				S_DC_CHK: begin
					state_q <= (pend_dc_q > dc_use_q) ? S_DC_START : S_IDLE;
				end
				S_DC_START: begin
					if ((RCW+1)'(raw_count_q) > (RCW+1)'(pend_dc_q) + (RCW+1)'(dc_use_q)) begin
						state_q <= S_DC_RM_RD;
					end else begin
						state_q <= S_DC_X_RD;
					end
				end
				S_DC_RM_RD: begin
					state_q <= S_DC_RM_SUB;
				end
				S_DC_RM_SUB: begin
					raw_sum_q   <= raw_sum_q - RSW'(raw_rd_q);
					raw_count_q <= raw_count_q - 1'b1;
					state_q     <= S_DC_X_RD;
				end
				S_DC_X_RD: begin
					state_q <= S_DC_DIV_LD;
				end
				S_DC_DIV_LD: begin
					pend_dc_q <= pend_dc_q - 1'b1;
					div_cnt_q <= DCNTW'(NW);
					div_sel_q <= 1'b0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == DCNTW'(1)) begin
						state_q <= div_sel_q ? S_CEN_T2 : S_DC_MEAN;
					end
				end
				S_DC_MEAN: begin
					state_q <= S_CEN_WR;
				end
				S_CEN_WR: begin
					wr_cen_q   <= (wr_cen_q == CEN_AW'(CEN_DEPTH - 1)) ? '0 : wr_cen_q + 1'b1;
					scount_q   <= scount_q + 1'b1;
					pend_rms_q <= pend_rms_q + 1'b1;
					state_q    <= S_CEN_ADD;
				end
				S_CEN_ADD: begin
					ssum_q <= ssum_q + SSW'(sq_q);
					if (pend_rms_q > rms_use_q) begin
						state_q <= S_CEN_START;
					end else begin
						state_q <= draining_q ? S_DRAIN : S_IDLE;
					end
				end
				S_CEN_START: begin
					if ((SCW+1)'(scount_q) > (SCW+1)'(pend_rms_q) + (SCW+1)'(rms_use_q)) begin
						state_q <= S_CEN_RM_RD;
					end else begin
						state_q <= S_CEN_C_RD;
					end
				end
				S_CEN_RM_RD: begin
					state_q <= S_CEN_RM_SQ;
				end
				S_CEN_RM_SQ: begin
					state_q <= S_CEN_RM_SUB;
				end
				S_CEN_RM_SUB: begin
					ssum_q   <= ssum_q - SSW'(sq_q);
					scount_q <= scount_q - 1'b1;
					state_q  <= S_CEN_C_RD;
				end
				S_CEN_C_RD: begin
					state_q <= S_CEN_C_GET;
				end
				S_CEN_C_GET: begin
					pend_rms_q <= pend_rms_q - 1'b1;
					state_q    <= S_CEN_SQ;
				end
				S_CEN_SQ: begin
					state_q <= S_CEN_SIL;
				end
				S_CEN_SIL: begin
					state_q <= S_CEN_CMP;
				end
				S_CEN_CMP: begin
					if ((scount_q == '0) || (64'(ssum_q) < 64'(sil_prod_q))) begin
						state_q <= S_OUT;
					end else begin
						div_cnt_q <= DCNTW'(SSW);
						div_sel_q <= 1'b1;
						state_q   <= S_DIV;
					end
				end
				S_CEN_T2: begin
					state_q <= S_CEN_DEC;
				end
				S_CEN_DEC: begin
					trig_q  <= trig_n;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_go) begin
						state_q <= S_IDLE;
					end
				end
				S_DRAIN: begin
					if (pend_dc_q != '0) begin
						state_q <= S_DC_START;
					end else if (pend_rms_q != '0) begin
						state_q <= S_CEN_START;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// stream closes after its last output or an empty drain
			if (end_stream) begin
				raw_sum_q   <= '0;
				ssum_q      <= '0;
				raw_count_q <= '0;
				scount_q    <= '0;
				pend_dc_q   <= '0;
				pend_rms_q  <= '0;
				active_q    <= 1'b0;
				draining_q  <= 1'b0;
				trig_q      <= 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q) inside
			S_DC_DIV_LD: begin
				x_q         <= raw_rd_q;
				mean_neg_q  <= raw_sum_q[RSW-1];
				mean_zero_q <= (raw_count_q == '0);
				num_q       <= DVW'(div1_num) << (DVW - NW);
				den_q       <= DDW'({raw_count_q, 1'b0});
				rem_q       <= '0;
				quo_q       <= '0;
			end
			S_DIV: begin
				rem_q <= div_rem_n;
				num_q <= num_q << 1;
				quo_q <= {quo_q[DVW-2:0], div_ge};
			end
			S_DC_MEAN: begin
				c_q <= c_full[CW-1:0];
			end
			S_CEN_WR, S_CEN_RM_SQ: begin
				sq_q <= sq_prod[SQW-1:0];
			end
			S_CEN_C_GET: begin
				c_q <= cen_rd_q;
			end
			S_CEN_SQ: begin
				sq_q    <= sq_prod[SQW-1:0];
				sl_sq_q <= SLW'(32'(silence_level_q) * 32'(silence_level_q));
				f2_q    <= FRAC_W'((32'(hyst_frac_q) * 32'(hyst_frac_q)) >> 16);
			end
			S_CEN_SIL: begin
				sil_prod_q <= SPW'(sl_sq_q) * SPW'(scount_q);
				lvl_q      <= LVL_SILENT;
			end
			S_CEN_CMP: begin
				num_q <= DVW'(ssum_q) << (DVW - SSW);
				den_q <= DDW'(scount_q);
				rem_q <= '0;
				quo_q <= '0;
			end
			S_CEN_T2: begin
				t2_q <= t2_full[T2W-1:FRAC_W];
			end
			S_CEN_DEC: begin
				lvl_q <= trig_n ? LVL_HIGH : LVL_LOW;
			end
			S_OUT: begin
				if (out_go) begin
					m_tdata_q <= OUT_W'(lvl_q);
					m_tlast_q <= out_last;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: hw/rtl/ahc_checker.sv
// port-level checks of the comparator outputs, bound to the top level
module ahc_checker
	import ahc_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic             m_tlast
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// only the three level codes appear
	a_level_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] == LVL_SILENT) || (m_tdata[1:0] == LVL_HIGH) ||
		             (m_tdata[1:0] == LVL_LOW))
		else $error("illegal level code");

	// padding bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_W-1:2] == '0))
		else $error("nonzero padding in result");

endmodule

bind adaptive_hysteresis_comparator_unit ahc_checker u_ahc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

FILE: bench/tb_top.sv
// testbench for the adaptive hysteresis comparator: directed, window extreme and random stream tests
`timescale 1ns / 1ps

module tb_top;
	import ahc_pkg::*;

	localparam int RAW_DEPTH = 2 * DEF_MAX_DC_HALF + 2;
	localparam int CEN_DEPTH = 2 * DEF_MAX_RMS_HALF + 2;
	localparam int SETTLE_CYCLES = 250;
	localparam logic [2:0] REG_UNUSED = 3'd5;

	typedef struct packed {
		logic [1:0] level;
		logic       last;
	} level_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// sample [15:0]
	logic [15:0] s_tdata = '0;
	// action [0]
	logic s_tuser = ACT_SAMPLE;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// level [1:0], zero fill [7:2]
	logic [OUT_W-1:0] m_tdata;
	logic m_tlast;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;

	adaptive_hysteresis_comparator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	longint raw_win[RAW_DEPTH];
	longint cen_win[CEN_DEPTH];
	longint raw_sum;
	longint unsigned sq_sum;
	int unsigned raw_cnt, sq_cnt, pend_dc, pend_rms, wr_raw, wr_cen, dc_use, rms_use;
	bit active, draining, trig_high;
	int unsigned cfg_dc, cfg_rms, cfg_sil, cfg_hmin, cfg_frac;

	level_t levels_due[$];
	int errors = 0;
	int requests = 0;
	int results = 0;
	int streams = 0;
	bit send_gaps = 1'b1;
	bit take_stalls = 1'b1;

	initial forever #5 clk = ~clk;

	initial begin
		#10ms;
		$display("tb_top: errors");
		$finish;
	end

	task automatic report(input string what);
		errors++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	function automatic void close_stream();
		raw_sum = 0; sq_sum = 0; raw_cnt = 0; sq_cnt = 0;
		pend_dc = 0; pend_rms = 0;
		active = 0; draining = 0; trig_high = 1;
	endfunction

	// centered value of the oldest pending raw sample
	function automatic longint center_next();
		int unsigned p;
		longint x, mean;
		longint unsigned mag, q;
		mean = 0;
		if (raw_cnt > pend_dc + dc_use) begin
			p = (wr_raw + RAW_DEPTH - raw_cnt) % RAW_DEPTH;
			raw_sum -= raw_win[p];
			raw_cnt--;
		end
		p = (wr_raw + RAW_DEPTH - pend_dc) % RAW_DEPTH;
		x = raw_win[p];
		if (raw_cnt > 0) begin
			mag = raw_sum < 0 ? -raw_sum : raw_sum;
			q = (2 * mag + raw_cnt) / (2 * longint'(raw_cnt));
			mean = raw_sum < 0 ? -longint'(q) : longint'(q);
		end
		pend_dc--;
		return x - mean;
	endfunction

	function automatic void push_centered(input longint c);
		cen_win[wr_cen] = c;
		wr_cen = (wr_cen + 1) % CEN_DEPTH;
		sq_sum += c * c;
		sq_cnt++;
		pend_rms++;
	endfunction

	// schmitt decision on the oldest pending centered value
	function automatic logic [1:0] judge_next();
		int unsigned p;
		longint c;
		longint unsigned c2, ms, f2, t2, sl;
		if (sq_cnt > pend_rms + rms_use) begin
			p = (wr_cen + CEN_DEPTH - sq_cnt) % CEN_DEPTH;
			c = cen_win[p];
			sq_sum -= c * c;
			sq_cnt--;
		end
		p = (wr_cen + CEN_DEPTH - pend_rms) % CEN_DEPTH;
		c = cen_win[p];
		pend_rms--;
		if (sq_cnt == 0) return LVL_SILENT;
		sl = cfg_sil;
		if (sq_sum < sl * sl * sq_cnt) return LVL_SILENT;
		ms = sq_sum / sq_cnt;
		f2 = (longint'(cfg_frac) * cfg_frac) >> 16;
		t2 = (ms >> 16) * f2 + (((ms & 64'hFFFF) * f2) >> 16);
		c2 = c * c;
		if (c >= 0 && c >= cfg_hmin && c2 >= t2)
			trig_high = 1;
		else if (c <= 0 && -c >= cfg_hmin && c2 >= t2)
			trig_high = 0;
		return trig_high ? LVL_HIGH : LVL_LOW;
	endfunction

	// level due for one accepted request, if any
	function automatic bit predict_level(input logic kind, input logic [15:0] smp,
			output level_t res);
		bit got;
		int unsigned guard;
		got = 0;
		res = '0;
		if (kind == ACT_SAMPLE) begin
			if (draining) return 0;
			if (!active) begin
				active = 1;
				trig_high = 1;
				dc_use = cfg_dc > DEF_MAX_DC_HALF ? DEF_MAX_DC_HALF : cfg_dc;
				rms_use = cfg_rms > DEF_MAX_RMS_HALF ? DEF_MAX_RMS_HALF : cfg_rms;
			end
			raw_win[wr_raw] = longint'($signed(smp));
			wr_raw = (wr_raw + 1) % RAW_DEPTH;
			raw_sum += longint'($signed(smp));
			raw_cnt++;
			pend_dc++;
			if (pend_dc > dc_use) begin
				push_centered(center_next());
				if (pend_rms > rms_use) begin
					res.level = judge_next();
					return 1;
				end
			end
			return 0;
		end
		if (!active) return 0;
		draining = 1;
		for (guard = 0; guard < RAW_DEPTH + CEN_DEPTH && !got; guard++) begin
			if (pend_dc > 0) begin
				push_centered(center_next());
				if (pend_rms > rms_use) begin
					res.level = judge_next();
					got = 1;
				end
			end else if (pend_rms > 0) begin
				res.level = judge_next();
				got = 1;
			end else begin
				break;
			end
		end
		if (!got) begin
			close_stream();
			return 0;
		end
		if (pend_dc == 0 && pend_rms == 0) begin
			res.last = 1;
			close_stream();
		end
		return 1;
	endfunction

	// result checker
	always @(posedge clk) begin
		level_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results++;
			if (levels_due.size() == 0) begin
				report("result with none due");
			end else begin
				want = levels_due.pop_front();
				if (m_tdata !== {{(OUT_W-2){1'b0}}, want.level})
					report($sformatf("level %h, due %h", m_tdata, want.level));
				if (m_tlast !== want.last)
					report($sformatf("tlast %b, due %b", m_tlast, want.last));
			end
		end
	end

	// result side stalls
	always @(negedge clk)
		m_tready <= take_stalls ? ($urandom_range(99) >= 21) : 1'b1;

	task automatic send_request(input logic kind, input logic [15:0] smp);
		level_t res;
		@(negedge clk);
		while (send_gaps && $urandom_range(99) < 21) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = kind;
		s_tdata = smp;
		do @(posedge clk); while (!s_tready);
		requests++;
		if (predict_level(kind, smp, res)) levels_due = {levels_due, res};
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (levels_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input int unsigned value);
		@(negedge clk);
		s_tvalid = 1'b0;
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
		paddr = APB_AW'(idx) << 2;
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		case (idx)
			REG_DC_HALF:   cfg_dc = value & 32'hFFF;
			REG_RMS_HALF:  cfg_rms = value & 32'h3FF;
			REG_SILENCE:   cfg_sil = value & 32'h7FFF;
			REG_HYST_MIN:  cfg_hmin = value & 32'h7FFF;
			REG_HYST_FRAC: cfg_frac = value & 32'hFFFF;
			default: ;
		endcase
	endtask

	task automatic configure(input int unsigned dch, rmsh, sil, hmin, frac);
		write_reg(REG_DC_HALF, dch);
		write_reg(REG_RMS_HALF, rmsh);
		write_reg(REG_SILENCE, sil);
		write_reg(REG_HYST_MIN, hmin);
		write_reg(REG_HYST_FRAC, frac);
	endtask

	task automatic drain_stream();
		while (active) send_request(ACT_FLUSH, 16'($urandom));
		streams++;
	endtask

	// tone with offset and noise, clipped to the sample range
	function automatic logic [15:0] tone_sample(input int n, offset, amp, period, noise);
		int v;
		v = offset + (((n / period) % 2) ? -amp : amp);
		if (noise > 0) v += $urandom_range(2 * noise) - noise;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return 16'(v);
	endfunction

	task automatic test_directed();
		logic [15:0] pattern[10] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF, 16'h8000,
			16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA, 16'h8000};
		// flush with no open stream
		send_request(ACT_FLUSH, 16'h0000);
		configure(2, 1, 0, 0, 16'hFFFF);
		foreach (pattern[i]) send_request(ACT_SAMPLE, pattern[i]);
		// sample after a flush while draining is dropped
		send_request(ACT_FLUSH, 16'h0000);
		send_request(ACT_SAMPLE, 16'h7FFF);
		drain_stream();
		wait_idle();
		// one sample windows, loud threshold registers
		configure(0, 0, 32767, 32767, 0);
		for (int i = 0; i < 6; i++) send_request(ACT_SAMPLE, pattern[i]);
		drain_stream();
		wait_idle();
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
	endtask

	task automatic test_window_extremes();
		// oversized windows saturate; short stream keeps it cheap
		configure(4095, 1023, 100, 200, 30000);
		for (int i = 0; i < 12; i++) send_request(ACT_SAMPLE, tone_sample(i, 300, 9000, 3, 500));
		// window size writes mid stream take effect at the next stream only
		wait_idle();
		configure(3, 2, 100, 200, 30000);
		for (int i = 0; i < 6; i++) send_request(ACT_SAMPLE, tone_sample(i, 0, 12000, 2, 0));
		drain_stream();
		wait_idle();
		configure(2048, 512, 50, 100, 20000);
		for (int i = 0; i < 30; i++) send_request(ACT_SAMPLE, tone_sample(i, -2000, 8000, 5, 800));
		drain_stream();
		wait_idle();
	endtask

	task automatic test_random();
		int len, offset, amp, period, noise;
		bool_loop: while (requests < 1450) begin
			configure($urandom_range(9) == 0 ? $urandom_range(60) : $urandom_range(1, 10),
				$urandom_range(9) == 0 ? $urandom_range(30) : $urandom_range(1, 5),
				$urandom_range(7) == 0 ? $urandom_range(32767) : $urandom_range(1500),
				$urandom_range(7) == 0 ? $urandom_range(32767) : $urandom_range(3000),
				$urandom_range(65535));
			len = $urandom_range(15, 70);
			offset = int'($urandom_range(12000)) - 6000;
			amp = $urandom_range(3) == 0 ? $urandom_range(800) : $urandom_range(26000);
			period = $urandom_range(1, 8);
			noise = $urandom_range(3000);
			send_gaps = (streams % 6) != 3;
			take_stalls = (streams % 6) != 3;
			for (int n = 0; n < len; n++) begin
				if ($urandom_range(19) == 0)
					send_request(ACT_SAMPLE, 16'($urandom));
				else
					send_request(ACT_SAMPLE, tone_sample(n, offset, amp, period, noise));
				if (streams == 5 && n == len / 2) wait_idle();
			end
			if ($urandom_range(4) == 0) begin
				send_request(ACT_FLUSH, 16'($urandom));
				send_request(ACT_SAMPLE, 16'($urandom));
			end
			drain_stream();
			if ($urandom_range(3) == 0) send_request(ACT_FLUSH, 16'($urandom));
			wait_idle();
		end
		send_gaps = 1'b1;
		take_stalls = 1'b1;
	endtask

	initial begin
		cfg_dc = DC_HALF_RST; cfg_rms = RMS_HALF_RST; cfg_sil = SILENCE_RST;
		cfg_hmin = HYST_MIN_RST; cfg_frac = HYST_FRAC_RST;
		wr_raw = 0; wr_cen = 0; dc_use = 0; rms_use = 0;
		close_stream();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_window_extremes();
		test_random();
		wait_idle();
		$display("covered %0d requests in %0d streams, %0d levels checked",
			requests, streams, results);
		if (errors == 0 && levels_due.size() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("%0d mismatches, %0d levels never seen", errors, levels_due.size());
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
